/* hdl/pcg_pkg.sv */
// Shared constants, codes and helper functions of the PCG32 generator.
package pcg_pkg;

    localparam logic [63:0] LCG_MULT   = 64'h5851_f42d_4c95_7f2d;
    localparam logic [63:0] MIX_K1     = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] MIX_K2     = 64'hc4ce_b9fe_1a85_ec53;
    localparam int          MIX_SHIFT  = 33;
    localparam int          FRAC_SHIFT = 9;
    localparam int          WORD_W     = 32;
    localparam int          FRAC_W     = 23;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic REG_SEED = 1'b0;

    function automatic logic [63:0] mix_xor(input logic [63:0] h);
        mix_xor = h ^ (h >> MIX_SHIFT);
    endfunction

    // xorshift high, then rotate right by the top five state bits
    function automatic logic [31:0] permute(input logic [63:0] old);
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        xs      = 32'(((old >> 18) ^ old) >> 27);
        rot     = old[63:59];
        dbl     = {xs, xs} >> rot;
        permute = dbl[31:0];
    endfunction

endpackage

/* hdl/pcg_mul64.sv */
// Shared 64x64 multiplier, low 64 bits, built from three 32x32 partial products.
module pcg_mul64
    import pcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;
    localparam logic [1:0] STEP_FIN = 2'd3;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;

    always_comb
    begin
        op_a = (step_reg == STEP_HL) ? a_reg[63:32] : a_reg[31:0];
        op_b = (step_reg == STEP_LH) ? b_reg[63:32] : b_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LL;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == STEP_FIN)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            prod_reg <= op_a * op_b;
            case (step_reg)
                STEP_LH:  sum_reg <= prod_reg;
                STEP_HL,
                STEP_FIN: sum_reg[63:32] <= sum_reg[63:32] + prod_reg[31:0];
                default:  sum_reg <= sum_reg;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = sum_reg;

endmodule

/* hdl/pcg_modulo.sv */
// Bit-serial 32-bit remainder unit, one dividend bit per cycle.
module pcg_modulo
    import pcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[WORD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
            rem_next = diff[WORD_W-1:0];
        else
            rem_next = trial[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/pcg32_random_generator_core.sv */
// PCG32 XSH-RR generator core: sequencer around a shared multiplier and modulo unit.
// Draw: one multiply advances the state, then the serial remainder unit reduces the word
//   to the span; when the span is full the remainder is skipped before m_tvalid.
// Reseed: six multiplies in turn; no result item.
// One item at a time: s_tready low until the item completes.
// Reset: seed clears to zero and the core seeds itself from it (not ready meanwhile).
module pcg32_random_generator_core
    import pcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // range_low[31:0], range_high[63:32]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // random_word[31:0], ranged_value[63:32],
                                   // unit_fraction[86:64], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1_GO,
        ST_K1_WAIT,
        ST_K2_GO,
        ST_K2_WAIT,
        ST_ADV_GO,
        ST_ADV_WAIT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_DRAW,
        JOB_SEED_A,
        JOB_SEED_B
    } job_t;

    state_t      state_reg;
    job_t        job_reg;
    logic [31:0] seed_reg;
    logic [63:0] acc_reg;
    logic [63:0] lcg_state_reg;
    logic [63:0] lcg_inc_reg;
    logic [31:0] word_reg;
    logic [31:0] low_reg;
    logic [31:0] span_reg;
    logic [31:0] ranged_reg;

    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_product;
    logic [63:0] mixed;
    logic        mod_start;
    logic        mod_done;
    logic [31:0] mod_rem;
    logic        cfg_write;
    logic [63:0] seed_word;
    logic [31:0] in_low;
    logic [31:0] in_high;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, word_reg[WORD_W-1:FRAC_SHIFT], ranged_reg, word_reg};

    assign in_low    = s_tdata[31:0];
    assign in_high   = s_tdata[63:32];
    assign seed_word = {31'd0, seed_reg, 1'b1};
    assign mixed     = mix_xor(mul_product);

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = MIX_K1;
        case (state_reg)
            ST_K1_GO:
            begin
                mul_start = 1'b1;
            end
            ST_K2_GO:
            begin
                mul_start = 1'b1;
                mul_b     = MIX_K2;
            end
            ST_ADV_GO:
            begin
                mul_start = 1'b1;
                mul_a     = lcg_state_reg;
                mul_b     = LCG_MULT;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign mod_start = (state_reg == ST_MOD_GO);

    pcg_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    pcg_modulo u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (word_reg),
        .divisor   (span_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            state_reg     <= ST_K1_GO;
            job_reg       <= JOB_SEED_A;
            acc_reg       <= mix_xor(64'd1);
            lcg_state_reg <= 64'd0;
            lcg_inc_reg   <= 64'd1;
            word_reg      <= 32'd0;
            low_reg       <= 32'd0;
            span_reg      <= 32'd0;
            ranged_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_SEED))
                seed_reg <= pwdata;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser == OP_RESEED)
                        begin
                            job_reg   <= JOB_SEED_A;
                            acc_reg   <= mix_xor(seed_word);
                            state_reg <= ST_K1_GO;
                        end
                        else
                        begin
                            job_reg   <= JOB_DRAW;
                            word_reg  <= permute(lcg_state_reg);
                            low_reg   <= in_low;
                            span_reg  <= in_high - in_low + 32'd1;
                            state_reg <= ST_ADV_GO;
                        end
                    end
                end
                ST_K1_GO:
                begin
                    state_reg <= ST_K1_WAIT;
                end
                ST_K1_WAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mixed;
                        state_reg <= ST_K2_GO;
                    end
                end
                ST_K2_GO:
                begin
                    state_reg <= ST_K2_WAIT;
                end
                ST_K2_WAIT:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mixed;
                        if (job_reg == JOB_SEED_A)
                        begin
                            lcg_inc_reg   <= {mixed[62:0], 1'b1};
                            lcg_state_reg <= 64'd0;
                        end
                        else
                        begin
                            lcg_state_reg <= lcg_state_reg + mixed;
                        end
                        state_reg <= ST_ADV_GO;
                    end
                end
                ST_ADV_GO:
                begin
                    state_reg <= ST_ADV_WAIT;
                end
                ST_ADV_WAIT:
                begin
                    if (mul_done)
                    begin
                        lcg_state_reg <= mul_product + lcg_inc_reg;
                        case (job_reg)
                            JOB_SEED_A:
                            begin
                                job_reg   <= JOB_SEED_B;
                                acc_reg   <= mix_xor(acc_reg);
                                state_reg <= ST_K1_GO;
                            end
                            JOB_DRAW:
                            begin
                                if (span_reg == 32'd0)
                                begin
                                    ranged_reg <= word_reg;
                                    state_reg  <= ST_OUT;
                                end
                                else
                                begin
                                    state_reg <= ST_MOD_GO;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MOD_GO:
                begin
                    state_reg <= ST_MOD_WAIT;
                end
                ST_MOD_WAIT:
                begin
                    if (mod_done)
                    begin
                        ranged_reg <= low_reg + mod_rem;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_K1_WAIT || state_reg == ST_K2_WAIT ||
                      state_reg == ST_ADV_WAIT))
        else $error("multiplier result outside a wait state");

    a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD_WAIT))
        else $error("remainder result outside its wait state");

    a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_inc_reg[0])
        else $error("increment became even");

    a_out_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("core not ready after result item taken");

endmodule
